### rtl/bitmap_membership_set_core_macros.svh
// Assertion helpers used by the block's top-level RTL.
`ifndef BITMAP_MEMBERSHIP_SET_CORE_MACROS_SVH
`define BITMAP_MEMBERSHIP_SET_CORE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define BMS_ASSERT_NOW(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define BMS_ASSERT_NEXT(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### rtl/bms_pkg.sv
package bms_pkg;

    localparam int DEF_CAPACITY = 4096;
    localparam int WORD_BITS    = 64;
    localparam int COUNT_W      = 13;
    localparam int COUNT_MAX    = 8191;

    typedef enum logic [1:0] {
        OP_CONTAINS = 2'd0,
        OP_INSERT   = 2'd1,
        OP_DELETE   = 2'd2,
        OP_CLEAR    = 2'd3
    } bms_op_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MODIFY,
        ST_CLR_REPLY
    } bms_state_t;

    typedef struct packed {
        bms_op_t     opcode;
        logic [31:0] value;
    } bms_in_t;

    typedef struct packed {
        logic               hit;
        logic               out_of_range;
        logic [COUNT_W-1:0] member_count;
    } bms_out_t;

endpackage

### rtl/bitmap_membership_set_core.sv
// Bitmap set of integer ids 0 .. CAPACITY-1 with a running member count. Each
// input word carries an opcode (contains, insert, delete, clear) and an id and
// yields exactly one result word: hit, out_of_range and the member count after
// the operation (saturated at 8191 when CAPACITY is larger). The bitmap lives
// in one single-port RAM of CEIL(CAPACITY/64) 64-bit words with a registered
// read. Contains, insert and delete read the id's word, then modify, write back
// and report once the output register can take the result. Clear zeroes the
// RAM one word a cycle, then reports. After reset the same clearing pass runs
// with s_ready low and no result. One item is in flight at a time; the result
// sits in an output register, so the next item is taken while a result waits
// on m_ready.
`include "bitmap_membership_set_core_macros.svh"

module bitmap_membership_set_core #(
    parameter int CAPACITY = bms_pkg::DEF_CAPACITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bms_pkg::bms_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bms_pkg::bms_out_t m_data
);
    import bms_pkg::*;

    localparam int WORDS  = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    // RAM port, driven by the controller
    logic                 rd_en;
    logic                 wr_en;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] rdata;

    // result hand-off from the controller into the output register
    logic     slot_free;
    logic     res_valid;
    bms_out_t res_data;

    logic     m_valid_reg, m_valid_next;
    bms_out_t m_data_reg, m_data_next;

    bms_ctrl #(
        .CAPACITY (CAPACITY),
        .WORDS    (WORDS),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res_data  (res_data),
        .rd_en     (rd_en),
        .wr_en     (wr_en),
        .addr      (addr),
        .wdata     (wdata),
        .rdata     (rdata)
    );

    bms_word_ram #(
        .DEPTH  (WORDS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .rd_en (rd_en),
        .wr_en (wr_en),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // The output register may take a new word when empty or being drained.
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid) begin
            // load the fresh result
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            // drop the word just taken
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the payload until the next result
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A result must never overwrite one that is still waiting.
    `BMS_ASSERT_NOW(a_no_overwrite, aclk, aresetn, res_valid, slot_free, "result overwrote pending word")
    // One item in flight: after an accept the input side closes.
    `BMS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted while busy")
    // A hit only comes from an id inside the set's range.
    `BMS_ASSERT_NOW(a_hit_in_range, aclk, aresetn, res_valid && res_data.hit, !res_data.out_of_range, "hit flagged out of range")

endmodule

### rtl/bms_word_ram.sv
module bms_word_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic                           wr_en,
    input  logic [ADDR_W-1:0]              addr,
    input  logic [bms_pkg::WORD_BITS-1:0]  wdata,
    output logic [bms_pkg::WORD_BITS-1:0]  rdata
);
    import bms_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        // hold the last read word while no read is issued
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bms_ctrl.sv
module bms_ctrl #(
    parameter int CAPACITY = bms_pkg::DEF_CAPACITY,
    parameter int WORDS    = (CAPACITY + bms_pkg::WORD_BITS - 1) / bms_pkg::WORD_BITS,
    parameter int ADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bms_pkg::bms_in_t               s_data,
    input  logic                           slot_free,
    output logic                           res_valid,
    output bms_pkg::bms_out_t              res_data,
    output logic                           rd_en,
    output logic                           wr_en,
    output logic [ADDR_W-1:0]              addr,
    output logic [bms_pkg::WORD_BITS-1:0]  wdata,
    input  logic [bms_pkg::WORD_BITS-1:0]  rdata
);
    import bms_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    bms_state_t        state_reg, state_next;
    bms_op_t           op_reg, op_next;
    logic [31:0]       val_reg, val_next;
    logic              oor_reg, oor_next;
    logic              reply_reg, reply_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              accept;
    logic              in_range_in;
    logic              sweep_last;
    logic              bit_set;
    logic              mod_hit;
    logic [EXT_W-1:0]  count_ext;

    assign accept      = s_valid && s_ready;
    assign in_range_in = s_data.value < 32'(CAPACITY);
    assign sweep_last  = sweep_addr_reg == ADDR_W'(WORDS - 1);
    assign bit_set     = rdata[val_reg[5:0]];

    always_comb begin
        case (op_reg)
            OP_CONTAINS: mod_hit = !oor_reg && bit_set;
            OP_INSERT:   mod_hit = !oor_reg && !bit_set;
            OP_DELETE:   mod_hit = !oor_reg && bit_set;
            default:     mod_hit = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP: begin
                if (sweep_last) begin
                    state_next = reply_reg ? ST_CLR_REPLY : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_data.opcode == OP_CLEAR) ? ST_SWEEP : ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLR_REPLY: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_SWEEP;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready         = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        addr            = val_reg[ADDR_W+5:6];
        wdata           = rdata;
        res_valid       = 1'b0;
        op_next         = op_reg;
        val_next        = val_reg;
        oor_next        = oor_reg;
        reply_next      = reply_reg;
        sweep_addr_next = sweep_addr_reg;
        count_next      = count_reg;
        case (state_reg)
            ST_SWEEP: begin
                wr_en           = 1'b1;
                addr            = sweep_addr_reg;
                wdata           = '0;
                count_next      = '0;
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                addr    = s_data.value[ADDR_W+5:6];
                if (accept) begin
                    op_next         = s_data.opcode;
                    val_next        = s_data.value;
                    oor_next        = !in_range_in;
                    rd_en           = in_range_in && (s_data.opcode != OP_CLEAR);
                    reply_next      = 1'b1;
                    sweep_addr_next = '0;
                end
            end
            ST_MODIFY: begin
                res_valid = slot_free;
                if (op_reg == OP_INSERT) begin
                    wdata = rdata | (WORD_BITS'(1) << val_reg[5:0]);
                end else begin
                    wdata = rdata & ~(WORD_BITS'(1) << val_reg[5:0]);
                end
                if (slot_free && mod_hit) begin
                    if (op_reg == OP_INSERT) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else if (op_reg == OP_DELETE) begin
                        wr_en = 1'b1;
                        if (count_reg != '0) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
            end
            ST_CLR_REPLY: begin
                res_valid = slot_free;
            end
            default: begin
            end
        endcase
    end

    // saturate the reported count to its field
    assign count_ext = EXT_W'(count_next);

    always_comb begin
        res_data.member_count = (count_ext > EXT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                                : count_ext[COUNT_W-1:0];
        if (state_reg == ST_MODIFY) begin
            res_data.hit          = mod_hit;
            res_data.out_of_range = oor_reg;
        end else begin
            res_data.hit          = 1'b0;
            res_data.out_of_range = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            reply_reg      <= 1'b0;
            sweep_addr_reg <= '0;
            count_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            reply_reg      <= reply_next;
            sweep_addr_reg <= sweep_addr_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        val_reg <= val_next;
        oor_reg <= oor_next;
    end

endmodule
